// ===== hw/rtl/bfd_pkg.sv =====
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types and constants for the binary frame deframer.
// ----------------------------------------------------------------------------
package bfd_pkg;

  localparam int BFD_QUEUE_DEPTH = 2;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;
  typedef logic [1:0]  cfg_idx_t;

  localparam cfg_idx_t CFG_SYNC_FIRST  = 2'd0;
  localparam cfg_idx_t CFG_SYNC_SECOND = 2'd1;
  localparam cfg_idx_t CFG_MAX_LENGTH  = 2'd2;

  localparam byte_t RST_SYNC_FIRST  = 8'd181;
  localparam byte_t RST_SYNC_SECOND = 8'd98;
  localparam word_t RST_MAX_LENGTH  = 16'd512;

  typedef enum logic [2:0] {
    ST_BUSY   = 3'd0,
    ST_REJECT = 3'd1,
    ST_GOOD   = 3'd2,
    ST_CKERR  = 3'd3,
    ST_LENERR = 3'd4
  } frame_status_t;

  // classified byte handed from the front part to the parser
  typedef struct packed {
    byte_t data;
    logic  is_sync1;
    logic  is_sync2;
  } item_t;

endpackage

// ===== hw/rtl/bfd_if.sv =====
// ----------------------------------------------------------------------------
// bfd_if
// Valid/ready channels of the deframer: received bytes in, results out.
// ----------------------------------------------------------------------------
interface bfd_in_if;
  logic           valid;
  logic           ready;
  bfd_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bfd_out_if;
  logic                   valid;
  logic                   ready;
  logic                   payload_valid;
  bfd_pkg::byte_t         payload_byte;
  bfd_pkg::word_t         payload_index;
  bfd_pkg::byte_t         frame_class;
  bfd_pkg::byte_t         frame_id;
  bfd_pkg::word_t         frame_length;
  bfd_pkg::frame_status_t frame_status;

  modport source (
    output valid, output payload_valid, output payload_byte, output payload_index,
    output frame_class, output frame_id, output frame_length, output frame_status,
    input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_byte, input payload_index,
    input frame_class, input frame_id, input frame_length, input frame_status,
    output ready
  );
endinterface

// ===== hw/rtl/bfd_front.sv =====
// ----------------------------------------------------------------------------
// bfd_front
// Input stage: registers each received byte and tags it against the sync
// byte values before it enters the queue.
// ----------------------------------------------------------------------------
module bfd_front (
  input  logic           clk,
  input  logic           rst_n,
  bfd_in_if.sink         in_chan,
  input  bfd_pkg::byte_t sync_first,
  input  bfd_pkg::byte_t sync_second,
  output logic           push_valid,
  input  logic           push_ready,
  output bfd_pkg::item_t push_item
);
  import bfd_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  take;

  assign in_chan.ready = !valid_r || push_ready;
  assign take          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.data     <= in_chan.rx_byte;
      item_r.is_sync1 <= (in_chan.rx_byte == sync_first);
      item_r.is_sync2 <= (in_chan.rx_byte == sync_second);
    end
  end

  assign push_valid = valid_r;
  assign push_item  = item_r;

endmodule

// ===== hw/rtl/bfd_queue.sv =====
// ----------------------------------------------------------------------------
// bfd_queue
// Short register queue between the input stage and the parser.
// ----------------------------------------------------------------------------
module bfd_queue #(
  parameter int DEPTH = bfd_pkg::BFD_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  bfd_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output bfd_pkg::item_t pop_item
);
  import bfd_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/bfd_back.sv =====
// ----------------------------------------------------------------------------
// bfd_back
// Frame parser: sync, header, payload and Fletcher-8 check, one byte per
// cycle while the result side does not stall, with a registered result stage.
// ----------------------------------------------------------------------------
module bfd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  bfd_pkg::item_t pop_item,
  input  bfd_pkg::word_t max_length,
  bfd_out_if.source      out_chan
);
  import bfd_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_SYNC2 = 6'b000010,
    PH_HEAD  = 6'b000100,
    PH_DATA  = 6'b001000,
    PH_CKA   = 6'b010000,
    PH_CKB   = 6'b100000
  } phase_t;

  phase_t  phase_r, phase_nxt;
  byte_t   sum_a_r, sum_a_nxt;
  byte_t   sum_b_r, sum_b_nxt;
  word_t   count_r, count_nxt;
  byte_t   class_r, class_nxt;
  byte_t   id_r, id_nxt;
  word_t   length_r, length_nxt;
  logic    bad_r, bad_nxt;

  logic          out_valid_r;
  logic          res_pv;
  byte_t         res_pb;
  word_t         res_pi;
  frame_status_t res_status;
  logic          step;
  byte_t         b;
  byte_t         add_a;
  byte_t         add_b;
  word_t         count_inc;
  word_t         head_length;

  assign pop_ready = !out_valid_r || out_chan.ready;
  assign step      = pop_valid && pop_ready;
  assign b         = pop_item.data;

  assign add_a       = sum_a_r + b;
  assign add_b       = sum_b_r + add_a;
  assign count_inc   = count_r + 1'b1;
  assign head_length = {b, length_r[7:0]};

  always_comb begin
    phase_nxt  = phase_r;
    sum_a_nxt  = sum_a_r;
    sum_b_nxt  = sum_b_r;
    count_nxt  = count_r;
    class_nxt  = class_r;
    id_nxt     = id_r;
    length_nxt = length_r;
    bad_nxt    = bad_r;
    res_pv     = 1'b0;
    res_pb     = '0;
    res_pi     = '0;
    res_status = ST_BUSY;
    case (phase_r)
      PH_SYNC2: begin
        if (pop_item.is_sync2) begin
          sum_a_nxt  = '0;
          sum_b_nxt  = '0;
          count_nxt  = '0;
          class_nxt  = '0;
          id_nxt     = '0;
          length_nxt = '0;
          bad_nxt    = 1'b0;
          phase_nxt  = PH_HEAD;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_HEAD: begin
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        case (count_r[1:0])
          2'd0: begin
            class_nxt = b;
            count_nxt = 16'd1;
          end
          2'd1: begin
            id_nxt    = b;
            count_nxt = 16'd2;
          end
          2'd2: begin
            length_nxt = {8'd0, b};
            count_nxt  = 16'd3;
          end
          default: begin
            length_nxt = head_length;
            count_nxt  = '0;
            if (head_length > max_length) begin
              res_status = ST_LENERR;
              phase_nxt  = PH_IDLE;
            end else if (head_length == '0) begin
              phase_nxt = PH_CKA;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        endcase
      end
      PH_DATA: begin
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        res_pv    = 1'b1;
        res_pb    = b;
        res_pi    = count_r;
        count_nxt = count_inc;
        if (count_inc >= length_r) begin
          phase_nxt = PH_CKA;
        end
      end
      PH_CKA: begin
        bad_nxt   = (b != sum_a_r);
        phase_nxt = PH_CKB;
      end
      PH_CKB: begin
        res_status = (bad_r || (b != sum_b_r)) ? ST_CKERR : ST_GOOD;
        phase_nxt  = PH_IDLE;
      end
      default: begin
        if (pop_item.is_sync1) begin
          phase_nxt = PH_SYNC2;
        end else begin
          phase_nxt  = PH_IDLE;
          res_status = ST_REJECT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      sum_a_r     <= '0;
      sum_b_r     <= '0;
      count_r     <= '0;
      class_r     <= '0;
      id_r        <= '0;
      length_r    <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        phase_r  <= phase_nxt;
        sum_a_r  <= sum_a_nxt;
        sum_b_r  <= sum_b_nxt;
        count_r  <= count_nxt;
        class_r  <= class_nxt;
        id_r     <= id_nxt;
        length_r <= length_nxt;
        bad_r    <= bad_nxt;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (step) begin
      out_chan.payload_valid <= res_pv;
      out_chan.payload_byte  <= res_pb;
      out_chan.payload_index <= res_pi;
      out_chan.frame_class   <= class_nxt;
      out_chan.frame_id      <= id_nxt;
      out_chan.frame_length  <= length_nxt;
      out_chan.frame_status  <= res_status;
    end
  end

  assign out_chan.valid = out_valid_r;

endmodule

// ===== hw/rtl/binary_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// binary_frame_deframer_top
// Byte-serial frame deframer with Fletcher-8 checksum check.
// ----------------------------------------------------------------------------
// One received byte is taken per transaction and every byte gives exactly one
// result transaction: payload bytes with their index, header fields as held,
// and a status (in progress, rejected while idle, frame good, checksum error,
// length error). The block sustains one byte per clock cycle while the result
// side does not stall; the figure is set by the parser, which steps its frame
// state and both 8-bit running sums once per cycle. A byte is registered in
// turn by the input stage when it is accepted, then by the queue, and then the
// parser steps on it and loads the result register. The queue lets the input
// keep taking bytes while a result waits. Configuration is written through
// cfg_we, cfg_index and cfg_wdata; the user must write it only while no frame
// data is in flight, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module binary_frame_deframer_top #(
  parameter int QUEUE_DEPTH = bfd_pkg::BFD_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  bfd_in_if.sink            in_chan,
  bfd_out_if.source         out_chan,
  input  logic              cfg_we,
  input  bfd_pkg::cfg_idx_t cfg_index,
  input  bfd_pkg::word_t    cfg_wdata
);
  import bfd_pkg::*;

  byte_t sync_first_r;
  byte_t sync_second_r;
  word_t max_length_r;

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= RST_SYNC_FIRST;
      sync_second_r <= RST_SYNC_SECOND;
      max_length_r  <= RST_MAX_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata[7:0];
        CFG_SYNC_SECOND: sync_second_r <= cfg_wdata[7:0];
        CFG_MAX_LENGTH:  max_length_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bfd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .sync_first  (sync_first_r),
    .sync_second (sync_second_r),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item)
  );

  bfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  bfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .max_length (max_length_r),
    .out_chan   (out_chan)
  );

endmodule

// ===== tb/bfd_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// bfd_tb_pkg
// Scoreboard for the deframer: follows the frame parser byte by byte, keeps
// the reports it expects and compares them with what the block sends out.
// ----------------------------------------------------------------------------
package bfd_tb_pkg;
  import bfd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SYNC2,
    PH_HEAD,
    PH_DATA,
    PH_CKA,
    PH_CKB
  } parse_phase_t;

  typedef struct packed {
    logic          payload_valid;
    byte_t         payload_byte;
    word_t         payload_index;
    byte_t         frame_class;
    byte_t         frame_id;
    word_t         frame_length;
    frame_status_t frame_status;
  } frame_report_t;

  class deframer_scoreboard;
    byte_t         sync_first;
    byte_t         sync_second;
    word_t         max_length;
    parse_phase_t  phase;
    byte_t         sum_a;
    byte_t         sum_b;
    word_t         count;
    byte_t         held_class;
    byte_t         held_id;
    word_t         held_length;
    logic          first_bad;
    frame_report_t pending_reports[$];
    int            failures;

    function new();
      sync_first  = RST_SYNC_FIRST;
      sync_second = RST_SYNC_SECOND;
      max_length  = RST_MAX_LENGTH;
      phase       = PH_IDLE;
      sum_a       = '0;
      sum_b       = '0;
      count       = '0;
      held_class  = '0;
      held_id     = '0;
      held_length = '0;
      first_bad   = 1'b0;
      failures    = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, word_t value);
      case (idx)
        CFG_SYNC_FIRST:  sync_first = value[7:0];
        CFG_SYNC_SECOND: sync_second = value[7:0];
        CFG_MAX_LENGTH:  max_length = value;
        default: ;
      endcase
    endfunction

    function void add_sums(byte_t b);
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    function void note_byte(byte_t b);
      frame_report_t r;
      r = '0;
      r.frame_status = ST_BUSY;
      case (phase)
        PH_SYNC2: begin
          if (b == sync_second) begin
            sum_a       = '0;
            sum_b       = '0;
            count       = '0;
            held_class  = '0;
            held_id     = '0;
            held_length = '0;
            first_bad   = 1'b0;
            phase       = PH_HEAD;
          end else begin
            phase = PH_IDLE;
          end
        end
        PH_HEAD: begin
          add_sums(b);
          case (count)
            16'd0: begin
              held_class = b;
              count = 16'd1;
            end
            16'd1: begin
              held_id = b;
              count = 16'd2;
            end
            16'd2: begin
              held_length = {8'h00, b};
              count = 16'd3;
            end
            default: begin
              held_length = {b, held_length[7:0]};
              count = '0;
              if (held_length > max_length) begin
                r.frame_status = ST_LENERR;
                phase = PH_IDLE;
              end else if (held_length == 16'd0) begin
                phase = PH_CKA;
              end else begin
                phase = PH_DATA;
              end
            end
          endcase
        end
        PH_DATA: begin
          add_sums(b);
          r.payload_valid = 1'b1;
          r.payload_byte  = b;
          r.payload_index = count;
          count = count + 16'd1;
          if (count >= held_length) phase = PH_CKA;
        end
        PH_CKA: begin
          first_bad = (b != sum_a);
          phase = PH_CKB;
        end
        PH_CKB: begin
          r.frame_status = (first_bad || b != sum_b) ? ST_CKERR : ST_GOOD;
          phase = PH_IDLE;
        end
        default: begin
          if (b == sync_first) begin
            phase = PH_SYNC2;
          end else begin
            phase = PH_IDLE;
            r.frame_status = ST_REJECT;
          end
        end
      endcase
      r.frame_class  = held_class;
      r.frame_id     = held_id;
      r.frame_length = held_length;
      pending_reports.push_back(r);
    endfunction

    function string describe(frame_report_t r);
      return $sformatf("pv=%0b byte=%02h idx=%0d class=%02h id=%02h len=%0d status=%0d",
                       r.payload_valid, r.payload_byte, r.payload_index, r.frame_class,
                       r.frame_id, r.frame_length, r.frame_status);
    endfunction

    function void check_report(frame_report_t got);
      frame_report_t want;
      if (pending_reports.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected transaction: %s", describe(got));
        return;
      end
      want = pending_reports.pop_front();
      if (got.payload_valid !== want.payload_valid || got.payload_byte !== want.payload_byte ||
          got.payload_index !== want.payload_index || got.frame_class !== want.frame_class ||
          got.frame_id !== want.frame_id || got.frame_length !== want.frame_length ||
          got.frame_status !== want.frame_status) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: expected %s", describe(want));
          $display("          actual   %s", describe(got));
        end
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the binary frame deframer: drives sync, header, payload and
// checksum bytes (well-formed, corrupted, oversized and broken frames plus
// line noise) under several sync and length settings, with random gaps and
// stalls on both channels, and checks every result against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
  import bfd_pkg::*;
  import bfd_tb_pkg::*;

  localparam int CK_INTACT  = 0;
  localparam int CK_BREAK_A = 1;
  localparam int CK_BREAK_B = 2;

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_index;
  word_t    cfg_wdata;

  bfd_in_if  in_if ();
  bfd_out_if out_if ();

  binary_frame_deframer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  deframer_scoreboard sb;
  byte_t sync_first_val;
  byte_t sync_second_val;
  word_t max_len_val;
  bit    calm = 1'b0;
  bit    hold_req = 1'b0;
  int    bytes_sent = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  // result side: random stalls, and a long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (80) @(negedge clk);
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= 6);
      end
    end
  end

  always @(posedge clk) begin : watch_results
    frame_report_t seen;
    if (rst_n && out_if.valid && out_if.ready) begin
      seen.payload_valid = out_if.payload_valid;
      seen.payload_byte  = out_if.payload_byte;
      seen.payload_index = out_if.payload_index;
      seen.frame_class   = out_if.frame_class;
      seen.frame_id      = out_if.frame_id;
      seen.frame_length  = out_if.frame_length;
      seen.frame_status  = out_if.frame_status;
      sb.check_report(seen);
    end
  end

  task automatic send_byte(byte_t b);
    if (!calm && $urandom_range(99) < 6) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(byte_t s1, byte_t s2, word_t lim);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SYNC_FIRST;
    cfg_wdata <= {8'h00, s1};
    @(negedge clk);
    cfg_index <= CFG_SYNC_SECOND;
    cfg_wdata <= {8'h00, s2};
    @(negedge clk);
    cfg_index <= CFG_MAX_LENGTH;
    cfg_wdata <= lim;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(CFG_SYNC_FIRST, {8'h00, s1});
    sb.write_reg(CFG_SYNC_SECOND, {8'h00, s2});
    sb.write_reg(CFG_MAX_LENGTH, lim);
    sync_first_val  = s1;
    sync_second_val = s2;
    max_len_val     = lim;
  endtask

  task automatic send_frame(byte_t cls, byte_t id, word_t len, int corrupt);
    byte_t hdr [4];
    byte_t ck_a;
    byte_t ck_b;
    byte_t d;
    hdr[0] = cls;
    hdr[1] = id;
    hdr[2] = len[7:0];
    hdr[3] = len[15:8];
    ck_a = '0;
    ck_b = '0;
    send_byte(sync_first_val);
    send_byte(sync_second_val);
    for (int i = 0; i < 4; i++) begin
      send_byte(hdr[i]);
      ck_a = ck_a + hdr[i];
      ck_b = ck_b + ck_a;
    end
    if (len > max_len_val) return;
    for (int i = 0; i < len; i++) begin
      d = byte_t'($urandom_range(255));
      send_byte(d);
      ck_a = ck_a + d;
      ck_b = ck_b + ck_a;
    end
    if (corrupt == CK_BREAK_A) ck_a = ck_a ^ byte_t'($urandom_range(255, 1));
    if (corrupt == CK_BREAK_B) ck_b = ck_b ^ byte_t'($urandom_range(255, 1));
    send_byte(ck_a);
    send_byte(ck_b);
  endtask

  task automatic random_traffic(int n_bytes);
    int    stop;
    int    pick;
    int    cap;
    word_t len;
    stop = bytes_sent + n_bytes;
    while (bytes_sent < stop) begin
      pick = $urandom_range(99);
      cap  = (max_len_val < 8) ? int'(max_len_val) : 8;
      len  = word_t'($urandom_range(cap, 0));
      if (pick < 70) begin
        send_frame(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)), len,
                   CK_INTACT);
      end else if (pick < 80) begin
        send_frame(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)), len,
                   (pick < 75) ? CK_BREAK_A : CK_BREAK_B);
      end else if (pick < 86) begin
        if (max_len_val != 16'hFFFF)
          send_frame(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)),
                     word_t'($urandom_range(32'hFFFF, max_len_val + 1)), CK_INTACT);
      end else if (pick < 91) begin
        send_byte(sync_first_val);
        send_byte(sync_second_val ^ byte_t'($urandom_range(255, 1)));
      end else if (pick < 95) begin
        // header cut short, the next frame's bytes land in its place
        if (max_len_val <= 64) begin
          send_byte(sync_first_val);
          send_byte(sync_second_val);
          repeat ($urandom_range(3, 1)) send_byte(byte_t'($urandom_range(255)));
        end
      end else begin
        repeat ($urandom_range(4, 1)) send_byte(byte_t'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.rx_byte   = '0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_SYNC_FIRST;
    cfg_wdata       = '0;
    sync_first_val  = RST_SYNC_FIRST;
    sync_second_val = RST_SYNC_SECOND;
    max_len_val     = RST_MAX_LENGTH;
    sb = new();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // noise while idle, a bad second sync, then short frames and an oversized one
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(sync_first_val);
    send_byte(8'h00);
    send_frame(8'h00, 8'hFF, 16'd0, CK_INTACT);
    send_frame(8'hFF, 8'h00, 16'd1, CK_BREAK_A);
    send_frame(8'hA5, 8'h5A, 16'hFFFF, CK_INTACT);

    set_config(8'h00, 8'hFF, 16'd0);
    hold_req = 1'b1;
    random_traffic(120);

    set_config(8'hFF, 8'h00, 16'hFFFF);
    calm = 1'b1;
    random_traffic(80);
    calm = 1'b0;
    send_frame(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)), 16'd300,
               CK_INTACT);
    random_traffic(40);

    set_config(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)),
               word_t'($urandom_range(16, 1)));
    random_traffic(60);
    wait_drained();
    hold_req = 1'b1;
    random_traffic(70);

    set_config(RST_SYNC_FIRST, RST_SYNC_SECOND, RST_MAX_LENGTH);
    random_traffic(120);

    wait_drained();
    repeat (8) @(negedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== binary_frame_deframer_top.f =====
hw/rtl/bfd_pkg.sv
hw/rtl/bfd_if.sv
hw/rtl/bfd_front.sv
hw/rtl/bfd_queue.sv
hw/rtl/bfd_back.sv
hw/rtl/binary_frame_deframer_top.sv
tb/bfd_tb_pkg.sv
tb/tb_top.sv
